// ===== design/mss_pkg.sv =====
// shared types and constants for the multi-slot soft timer
package mss_pkg;

    // default slot count and per-item result cap
    localparam int TIMER_SLOTS_DEF = 16;
    localparam int RES_CAP         = 17;
    localparam int RES_CNT_W       = $clog2(RES_CAP + 1);

    localparam logic [7:0]  MARGIN_RESET = 8'd2;
    localparam logic [31:0] REM_SAT      = 32'hFFFF_FFFF;

    // input beat kind
    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_START  = 2'd1,
        KIND_CANCEL = 2'd2,
        KIND_QUERY  = 2'd3
    } kind_t;

    // result beat kind
    typedef enum logic [2:0] {
        RK_STARTED   = 3'd0,
        RK_EXHAUSTED = 3'd1,
        RK_CANCELLED = 3'd2,
        RK_REJECTED  = 3'd3,
        RK_REMAINING = 3'd4,
        RK_EXPIRED   = 3'd5
    } res_kind_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QREAD,
        ST_QSAT,
        ST_LIMIT,
        ST_SCAN,
        ST_DECIDE,
        ST_FLUSH
    } state_t;

    // control from sequencer to the compare unit
    typedef struct packed {
        logic clear;
        logic step;
        logic active;
    } scan_ctl_t;

endpackage

// ===== design/mss_expiry_ram.sv =====
// expiry time memory, one write port and one registered read port
module mss_expiry_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [63:0]       wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [63:0]       rdata
);

    logic [63:0] mem [DEPTH];
    logic [63:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/mss_scan_unit.sv =====
// shared compare unit: tracks the earliest due slot over one pass
module mss_scan_unit #(
    parameter int TIMER_SLOTS = mss_pkg::TIMER_SLOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  mss_pkg::scan_ctl_t  scan_ctl,
    input  logic [((TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1)-1:0] step_slot,
    input  logic [63:0]         expiry,
    input  logic [63:0]         limit,
    output logic                found,
    output logic [((TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1)-1:0] best_slot
);
    import mss_pkg::*;

    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    logic              found_reg, found_next;
    logic [SLOT_W-1:0] best_slot_reg, best_slot_next;
    logic [63:0]       best_exp_reg, best_exp_next;
    logic              take;

    // strict compare keeps the lower slot on ties, slots come in ascending order
    assign take = scan_ctl.step && scan_ctl.active && (expiry <= limit) &&
                  (!found_reg || (expiry < best_exp_reg));

    always_comb begin
        found_next     = found_reg;
        best_slot_next = best_slot_reg;
        best_exp_next  = best_exp_reg;
        if (scan_ctl.clear) begin
            found_next = 1'b0;
        end else if (take) begin
            found_next     = 1'b1;
            best_slot_next = step_slot;
            best_exp_next  = expiry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else begin
            found_reg <= found_next;
        end
        best_slot_reg <= best_slot_next;
        best_exp_reg  <= best_exp_next;
    end

    assign found     = found_reg;
    assign best_slot = best_slot_reg;

endmodule

// ===== design/multi_slot_soft_timer.sv =====
// top level of the multi-slot one-shot soft timer
//
// Keeps a 64-bit microsecond time and TIMER_SLOTS one-shot timers. Input beats
// are tick (time + 1), start (claim lowest free slot), cancel and query.
// After a tick or a start every timer due within early_margin of the current
// time comes out as an expired beat, earliest first, ties to the lower slot,
// at most 17 result beats per input beat; m_tlast marks the final one and a
// tick with nothing due gives no beat. Expiry times live in a single-port-read
// memory and one compare unit walks it a slot a cycle. A cancel goes straight
// to the flush step, a query reads the memory and saturates the remaining
// time before it. A tick or a start sets the due limit, then makes one pass
// over the slots per expired timer plus a final pass that finds nothing
// (skipped once the cap is hit), and then a flush step whenever the item
// gives any beat. A full output register holds the decide and flush steps.
// s_tready is high only while the sequencer is idle; a finished beat may
// still wait in the output register while the next input is taken.
module multi_slot_soft_timer #(
    parameter int TIMER_SLOTS = mss_pkg::TIMER_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config: early_margin
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] run_len_us, [39:32] slot_sel
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] slot_id, [39:8] remaining_us
    output logic [2:0]  m_tuser,   // [2:0] result_kind
    output logic        m_tlast
);
    import mss_pkg::*;

    localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);

    // sequencer and time state
    state_t                  state_reg, state_next;
    logic [63:0]             now_reg, now_next;
    logic [7:0]              margin_reg;
    logic [TIMER_SLOTS-1:0]  active_reg, active_next;
    logic [7:0]              id_reg, id_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [RES_CNT_W-1:0]    res_cnt_reg, res_cnt_next;
    logic [63:0]             limit_reg, limit_next;
    logic [63:0]             q_diff_reg, q_diff_next;
    logic                    q_live_reg, q_live_next;

    // pending result, held until we know whether it is the last one
    logic                    pend_valid_reg, pend_valid_next;
    res_kind_t               pend_kind_reg, pend_kind_next;
    logic [7:0]              pend_slot_reg, pend_slot_next;
    logic [31:0]             pend_rem_reg, pend_rem_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    res_kind_t               out_kind_reg, out_kind_next;
    logic [7:0]              out_slot_reg, out_slot_next;
    logic [31:0]             out_rem_reg, out_rem_next;
    logic                    out_last_reg, out_last_next;

    // input beat fields
    kind_t                   in_kind;
    logic [31:0]             in_dur;
    logic [7:0]              in_id;
    logic                    in_fire;
    logic                    out_free;

    // free slot search
    logic                    free_found;
    logic [SLOT_W-1:0]       free_slot;

    // memory and compare unit hookup
    logic                    ram_we, ram_re;
    logic [SLOT_W-1:0]       ram_waddr, ram_raddr;
    logic [63:0]             ram_wdata, ram_rdata;
    scan_ctl_t               scan_ctl;
    logic [SLOT_W-1:0]       scan_slot;
    logic                    scan_found;
    logic [SLOT_W-1:0]       scan_best;

    logic                    id_in_range;
    logic                    in_id_in_range;
    logic                    cap_hit;
    logic [64:0]             limit_sum;

    assign in_kind  = kind_t'(s_tuser);
    assign in_dur   = s_tdata[31:0];
    assign in_id    = s_tdata[39:32];
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign id_in_range    = id_reg < 8'(TIMER_SLOTS);
    assign in_id_in_range = in_id < 8'(TIMER_SLOTS);
    assign cap_hit        = res_cnt_reg == RES_CNT_W'(RES_CAP - 1);

    // slot being compared this cycle lags the read address by one
    assign scan_slot = SLOT_W'(cnt_reg - CNT_W'(1));

    // saturating now + margin for the due test
    assign limit_sum = {1'b0, now_reg} + {57'd0, margin_reg};

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    mss_expiry_ram #(
        .DEPTH  (TIMER_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mss_scan_unit #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .scan_ctl  (scan_ctl),
        .step_slot (scan_slot),
        .expiry    (ram_rdata),
        .limit     (limit_reg),
        .found     (scan_found),
        .best_slot (scan_best)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (in_kind)
                        KIND_TICK, KIND_START: state_next = ST_LIMIT;
                        KIND_CANCEL:           state_next = ST_FLUSH;
                        KIND_QUERY:            state_next = ST_QREAD;
                        default:               state_next = ST_IDLE;
                    endcase
                end
            end
            ST_QREAD: state_next = ST_QSAT;
            ST_QSAT:  state_next = ST_FLUSH;
            ST_LIMIT: state_next = ST_SCAN;
            ST_SCAN: begin
                if (cnt_reg == CNT_W'(TIMER_SLOTS)) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (scan_found) begin
                    if (!pend_valid_reg || out_free) begin
                        state_next = cap_hit ? ST_FLUSH : ST_SCAN;
                    end
                end else begin
                    state_next = pend_valid_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and control
    always_comb begin
        s_tready        = 1'b0;
        now_next        = now_reg;
        active_next     = active_reg;
        id_next         = id_reg;
        cnt_next        = cnt_reg;
        res_cnt_next    = res_cnt_reg;
        limit_next      = limit_reg;
        q_diff_next     = q_diff_reg;
        q_live_next     = q_live_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_slot_next  = pend_slot_reg;
        pend_rem_next   = pend_rem_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_slot_next   = out_slot_reg;
        out_rem_next    = out_rem_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = free_slot;
        ram_wdata       = now_reg + {32'd0, in_dur};
        ram_re          = 1'b0;
        ram_raddr       = scan_slot;
        scan_ctl        = '0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (in_fire) begin
                    id_next = in_id;
                    case (in_kind)
                        KIND_TICK: begin
                            now_next        = now_reg + 64'd1;
                            res_cnt_next    = '0;
                            pend_valid_next = 1'b0;
                        end
                        KIND_START: begin
                            res_cnt_next    = RES_CNT_W'(1);
                            pend_valid_next = 1'b1;
                            if (free_found) begin
                                active_next[free_slot] = 1'b1;
                                ram_we         = 1'b1;
                                pend_kind_next = RK_STARTED;
                                pend_slot_next = 8'(free_slot);
                                pend_rem_next  = in_dur;
                            end else begin
                                pend_kind_next = RK_EXHAUSTED;
                                pend_slot_next = '0;
                                pend_rem_next  = '0;
                            end
                        end
                        KIND_CANCEL: begin
                            pend_valid_next = 1'b1;
                            pend_slot_next  = in_id;
                            pend_rem_next   = '0;
                            if (in_id_in_range) begin
                                active_next[SLOT_W'(in_id)] = 1'b0;
                                pend_kind_next = RK_CANCELLED;
                            end else begin
                                pend_kind_next = RK_REJECTED;
                            end
                        end
                        KIND_QUERY: begin
                            ram_re    = in_id_in_range;
                            ram_raddr = SLOT_W'(in_id);
                        end
                        default: begin
                            pend_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_QREAD: begin
                q_diff_next = ram_rdata - now_reg;
                q_live_next = (id_in_range ? active_reg[SLOT_W'(id_reg)] : 1'b0) &&
                              (ram_rdata > now_reg);
            end
            ST_QSAT: begin
                pend_valid_next = 1'b1;
                pend_kind_next  = RK_REMAINING;
                pend_slot_next  = id_reg;
                if (!q_live_reg) begin
                    pend_rem_next = '0;
                end else if (q_diff_reg[63:32] != 32'd0) begin
                    pend_rem_next = REM_SAT;
                end else begin
                    pend_rem_next = q_diff_reg[31:0];
                end
            end
            ST_LIMIT: begin
                limit_next     = limit_sum[64] ? '1 : limit_sum[63:0];
                scan_ctl.clear = 1'b1;
                cnt_next       = '0;
            end
            ST_SCAN: begin
                ram_re          = cnt_reg < CNT_W'(TIMER_SLOTS);
                ram_raddr       = SLOT_W'(cnt_reg);
                scan_ctl.step   = cnt_reg != '0;
                scan_ctl.active = active_reg[scan_slot];
                cnt_next        = cnt_reg + CNT_W'(1);
            end
            ST_DECIDE: begin
                if (scan_found && (!pend_valid_reg || out_free)) begin
                    if (pend_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_kind_next  = pend_kind_reg;
                        out_slot_next  = pend_slot_reg;
                        out_rem_next   = pend_rem_reg;
                        out_last_next  = 1'b0;
                    end
                    active_next[scan_best] = 1'b0;
                    pend_valid_next = 1'b1;
                    pend_kind_next  = RK_EXPIRED;
                    pend_slot_next  = 8'(scan_best);
                    pend_rem_next   = '0;
                    res_cnt_next    = res_cnt_reg + RES_CNT_W'(1);
                    if (!cap_hit) begin
                        scan_ctl.clear = 1'b1;
                        cnt_next       = '0;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = pend_kind_reg;
                    out_slot_next   = pend_slot_reg;
                    out_rem_next    = pend_rem_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
                pend_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            margin_reg     <= MARGIN_RESET;
            active_reg     <= '0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            if (cfg_wr_en) begin
                margin_reg <= cfg_wr_data;
            end
            active_reg     <= active_next;
            res_cnt_reg    <= res_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            cnt_reg        <= cnt_next;
        end
        id_reg        <= id_next;
        limit_reg     <= limit_next;
        q_diff_reg    <= q_diff_next;
        q_live_reg    <= q_live_next;
        pend_kind_reg <= pend_kind_next;
        pend_slot_reg <= pend_slot_next;
        pend_rem_reg  <= pend_rem_next;
        out_kind_reg  <= out_kind_next;
        out_slot_reg  <= out_slot_next;
        out_rem_reg   <= out_rem_next;
        out_last_reg  <= out_last_next;
    end

    // result channel drive
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rem_reg, out_slot_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // no input is taken while a result of the previous one is still pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("input taken with a result still pending");

    // never more results per input beat than the cap
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_cnt_reg <= RES_CNT_W'(RES_CAP))
        else $error("result count above cap");

    // a cancel always leaves exactly one result pending for the flush
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (s_tuser == KIND_CANCEL)) |=> (pend_valid_reg && (state_reg == ST_FLUSH)))
        else $error("cancel did not produce a pending result");

    // the slot walk never runs past the last slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cnt_reg <= CNT_W'(TIMER_SLOTS)))
        else $error("scan counter overran the slot count");

endmodule
